@@ sv/bmsi_pkg.sv @@
package bmsi_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_PRG_MAP = 2'd2,
    MODE_CHR_MAP = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_A0_LINE      = 2'd0,
    CFG_A1_LINE      = 2'd1,
    CFG_FULL_VARIANT = 2'd2,
    CFG_HONOR_REPEAT = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    SEL_RELOAD_LO = 2'd0,
    SEL_RELOAD_HI = 2'd1,
    SEL_CONTROL   = 2'd2,
    SEL_ACK       = 2'd3
  } sel_t;

  localparam logic [3:0] REGION_PRG0   = 4'h8;
  localparam logic [3:0] REGION_MIRROR = 4'h9;
  localparam logic [3:0] REGION_PRG1   = 4'hA;
  localparam logic [3:0] REGION_CHR_LO = 4'hB;
  localparam logic [3:0] REGION_CHR_HI = 4'hE;
  localparam logic [3:0] REGION_IRQ    = 4'hF;

  localparam logic signed [10:0] PRESCALE_PERIOD = 11'sd341;
  localparam logic signed [10:0] PRESCALE_STEP   = 11'sd3;
  localparam logic [6:0]         FIXED_BANK_HI   = 7'h7F;

  localparam int CFG_WIDTH  = 4;
  localparam int BANK_WIDTH = 12;

  typedef struct packed {
    logic [3:0] a0_line;
    logic [3:0] a1_line;
    logic       full_variant;
    logic       honor_repeat;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] address;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [BANK_WIDTH-1:0] bank;
    logic [1:0]            mirroring;
    logic                  irq;
  } result_t;

endpackage

@@ sv/bmsi_core.sv @@
module bmsi_core (
  input  logic            clk,
  input  logic            rst,
  input  bmsi_pkg::cfg_t  cfg,
  input  logic            step,
  input  bmsi_pkg::item_t item,
  output bmsi_pkg::result_t res
);
  import bmsi_pkg::*;

  logic [7:0]             program_banks [2];
  logic [BANK_WIDTH-1:0]  pattern_banks [8];
  logic [7:0]             mirror_setting;
  logic [7:0]             misc_setting;
  logic [7:0]             irq_reload;
  logic [2:0]             irq_control;
  logic [7:0]             irq_counter;
  logic signed [10:0]     prescaler;
  logic                   irq_pending;

  logic [7:0]             program_banks_next [2];
  logic [BANK_WIDTH-1:0]  pattern_banks_next [8];
  logic [7:0]             mirror_setting_next;
  logic [7:0]             misc_setting_next;
  logic [7:0]             irq_reload_next;
  logic [2:0]             irq_control_next;
  logic [7:0]             irq_counter_next;
  logic signed [10:0]     prescaler_next;
  logic                   irq_pending_next;

  logic [1:0]             sel;
  logic [3:0]             region;
  logic [3:0]             chr_off;
  logic [2:0]             chr_idx;
  logic signed [10:0]     pre_dec;
  logic                   count_en;
  logic [7:0]             cnt_inc;
  logic [1:0]             slot;

  assign sel     = {item.address[cfg.a1_line], item.address[cfg.a0_line]};
  assign region  = item.address[15:12];
  assign chr_off = region - REGION_CHR_LO;
  assign chr_idx = {chr_off[1:0], sel[1]};
  assign pre_dec = prescaler - PRESCALE_STEP;
  assign cnt_inc = irq_counter + 8'd1;

  always_comb begin
    program_banks_next  = program_banks;
    pattern_banks_next  = pattern_banks;
    mirror_setting_next = mirror_setting;
    misc_setting_next   = misc_setting;
    irq_reload_next     = irq_reload;
    irq_control_next    = irq_control;
    irq_counter_next    = irq_counter;
    prescaler_next      = prescaler;
    irq_pending_next    = irq_pending;
    count_en            = 1'b0;

    if (item.mode == MODE_WRITE && item.address[15]) begin
      case (region) inside
        REGION_PRG0: program_banks_next[0] = item.data;
        REGION_PRG1: program_banks_next[1] = item.data;
        REGION_MIRROR: begin
          if (!cfg.full_variant || sel == SEL_RELOAD_LO) begin
            mirror_setting_next = item.data;
          end else if (sel == SEL_CONTROL) begin
            misc_setting_next = item.data;
          end
        end
        REGION_IRQ: begin
          if (cfg.full_variant) begin
            unique case (sel_t'(sel))
              SEL_RELOAD_LO: irq_reload_next = {irq_reload[7:4], item.data[3:0]};
              SEL_RELOAD_HI: irq_reload_next = {item.data[3:0], irq_reload[3:0]};
              SEL_CONTROL: begin
                irq_control_next = item.data[2:0];
                irq_pending_next = 1'b0;
                if (item.data[1]) begin
                  irq_counter_next = irq_reload;
                  prescaler_next   = PRESCALE_PERIOD;
                end
              end
              SEL_ACK: begin
                irq_pending_next = 1'b0;
                if (cfg.honor_repeat) begin
                  irq_control_next = {irq_control[2], irq_control[0], irq_control[0]};
                end
              end
              default: irq_pending_next = irq_pending;
            endcase
          end
        end
        [REGION_CHR_LO:REGION_CHR_HI]: begin
          if (sel[0]) begin
            pattern_banks_next[chr_idx] = {item.data, pattern_banks[chr_idx][3:0]};
          end else begin
            pattern_banks_next[chr_idx] = {pattern_banks[chr_idx][11:4], item.data[3:0]};
          end
        end
        default: ;
      endcase
    end

    if (item.mode == MODE_TICK && cfg.full_variant && irq_control[1]) begin
      if (irq_control[2]) begin
        count_en = 1'b1;
      end else begin
        count_en       = (pre_dec <= 11'sd0);
        prescaler_next = count_en ? pre_dec + PRESCALE_PERIOD : pre_dec;
      end
      if (count_en) begin
        if (cnt_inc == 8'd0) begin
          irq_counter_next = irq_reload;
          irq_pending_next = 1'b1;
        end else begin
          irq_counter_next = cnt_inc;
        end
      end
    end
  end

  always_comb begin
    slot = item.address[14:13];
    if (cfg.full_variant && !slot[0] && misc_setting[1]) begin
      slot[1] = ~slot[1];
    end
    res.bank = '0;
    case (item.mode)
      MODE_PRG_MAP: begin
        if (slot[1]) begin
          res.bank = {4'h0, FIXED_BANK_HI, slot[0]};
        end else begin
          res.bank = {4'h0, program_banks[slot[0]]};
        end
      end
      MODE_CHR_MAP: res.bank = pattern_banks[item.address[12:10]];
      default: res.bank = '0;
    endcase
    res.mirroring = cfg.full_variant ? mirror_setting_next[1:0]
                                     : {1'b0, mirror_setting_next[0]};
    res.irq       = irq_pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      program_banks[0] <= '0;
      program_banks[1] <= '0;
      for (int i = 0; i < 8; i++) begin
        pattern_banks[i] <= BANK_WIDTH'(i);
      end
      mirror_setting <= '0;
      misc_setting   <= '0;
      irq_reload     <= '0;
      irq_control    <= '0;
      irq_counter    <= '0;
      prescaler      <= '0;
      irq_pending    <= 1'b0;
    end else if (step) begin
      program_banks  <= program_banks_next;
      pattern_banks  <= pattern_banks_next;
      mirror_setting <= mirror_setting_next;
      misc_setting   <= misc_setting_next;
      irq_reload     <= irq_reload_next;
      irq_control    <= irq_control_next;
      irq_counter    <= irq_counter_next;
      prescaler      <= prescaler_next;
      irq_pending    <= irq_pending_next;
    end
  end

endmodule

@@ sv/bank_mapper_with_scanline_irq_unit.sv @@
// Channel  Direction  Ports                              Contents
// s        in         s_tvalid s_tready s_tdata s_tuser  one request per item
// m        out        m_tvalid m_tready m_tdata          one result per request
// cfg      in         cfg_we cfg_index cfg_data          register writes
//
// Each request passes through the input register, then through the decode and
// bank logic into the result register.
// A new request is taken every cycle while results drain.
// Reset clears the pipeline valids and loads the bank state and the config
// registers with their defaults.
// A stalled result holds the result register, which holds the input register.
module bank_mapper_with_scanline_irq_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // address[15:0], data[23:16]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // bank[11:0], mirroring[13:12], irq[14], zero[15]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [bmsi_pkg::CFG_WIDTH-1:0] cfg_data
);
  import bmsi_pkg::*;

  cfg_t    cfg;
  logic    in_valid;
  item_t   in_item;
  result_t res;
  result_t out_res;
  logic    advance;
  logic    step;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step     = in_valid && advance;
  assign m_tdata  = {1'b0, out_res.irq, out_res.mirroring, out_res.bank};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.a0_line      <= 4'd0;
      cfg.a1_line      <= 4'd1;
      cfg.full_variant <= 1'b1;
      cfg.honor_repeat <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_A0_LINE:      cfg.a0_line      <= cfg_data[3:0];
        CFG_A1_LINE:      cfg.a1_line      <= cfg_data[3:0];
        CFG_FULL_VARIANT: cfg.full_variant <= cfg_data[0];
        CFG_HONOR_REPEAT: cfg.honor_repeat <= cfg_data[0];
        default:          cfg <= cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_item.mode    <= mode_t'(s_tuser);
      in_item.address <= s_tdata[15:0];
      in_item.data    <= s_tdata[23:16];
    end
  end

  bmsi_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (step),
    .item (in_item),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    step |-> (!m_tvalid || m_tready))
    else $error("result register overwritten while held");

  a_bank_zero: assert property (@(posedge clk) disable iff (rst)
    step && (in_item.mode == MODE_WRITE || in_item.mode == MODE_TICK) |-> res.bank == '0)
    else $error("bank nonzero on a write or tick");

  a_reduced_mirror: assert property (@(posedge clk) disable iff (rst)
    step && !cfg.full_variant |-> !res.mirroring[1])
    else $error("single-screen mirroring in reduced variant");

  a_result_capture: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid && m_tdata[11:0] == $past(res.bank))
    else $error("result register missed a result");
`endif

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bmsi_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // address[15:0], data[23:16]
  logic [1:0]  s_tuser = '0;   // mode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // bank[11:0], mirroring[13:12], irq[14], zero[15]
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  bank_mapper_with_scanline_irq_unit uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // mapper state mirror
  logic [3:0]  cfg_a0, cfg_a1;
  logic        cfg_full, cfg_repeat;
  logic [7:0]  prg_bank [2];
  logic [11:0] chr_bank [8];
  logic [7:0]  mirror_reg, misc_reg, irq_latch, irq_count;
  logic [2:0]  irq_ctrl;
  int          prescale;
  logic        irq_flag;

  item_t   bus_requests [$];
  result_t due_outputs [$];
  item_t   on_bus;
  int      send_idle = 0;
  int      recv_stall = 0;
  bit      hold_send = 1'b0;
  int      errors = 0;
  int      cycle_count = 0;

  task automatic reset_mapper();
    cfg_a0 = 4'd0;
    cfg_a1 = 4'd1;
    cfg_full = 1'b1;
    cfg_repeat = 1'b1;
    prg_bank[0] = '0;
    prg_bank[1] = '0;
    for (int i = 0; i < 8; i++) chr_bank[i] = 12'(i);
    mirror_reg = '0;
    misc_reg = '0;
    irq_latch = '0;
    irq_ctrl = '0;
    irq_count = '0;
    prescale = 0;
    irq_flag = 1'b0;
  endtask

  function automatic result_t mapper_step(item_t it);
    result_t    r;
    sel_t       sel;
    logic [3:0] region;
    logic [3:0] off;
    logic [2:0] idx;
    logic [1:0] slot;
    logic       clock_now;
    r = '0;
    case (it.mode)
      MODE_WRITE: if (it.address[15]) begin
        sel = sel_t'({it.address[cfg_a1], it.address[cfg_a0]});
        region = it.address[15:12];
        case (region)
          REGION_PRG0, REGION_PRG1: prg_bank[region[1]] = it.data;
          REGION_MIRROR: begin
            if (!cfg_full || sel == SEL_RELOAD_LO) mirror_reg = it.data;
            else if (sel == SEL_CONTROL) misc_reg = it.data;
          end
          REGION_IRQ: if (cfg_full) begin
            case (sel)
              SEL_RELOAD_LO: irq_latch[3:0] = it.data[3:0];
              SEL_RELOAD_HI: irq_latch[7:4] = it.data[3:0];
              SEL_CONTROL: begin
                irq_ctrl = it.data[2:0];
                if (irq_ctrl[1]) begin
                  irq_count = irq_latch;
                  prescale = PRESCALE_PERIOD;
                end
                irq_flag = 1'b0;
              end
              SEL_ACK: begin
                if (cfg_repeat) irq_ctrl[1] = irq_ctrl[0];
                irq_flag = 1'b0;
              end
            endcase
          end
          default: begin
            off = region - REGION_CHR_LO;
            idx = {off[1:0], sel[1]};
            if (sel[0]) chr_bank[idx] = {it.data, chr_bank[idx][3:0]};
            else chr_bank[idx] = {chr_bank[idx][11:4], it.data[3:0]};
          end
        endcase
      end
      MODE_TICK: if (cfg_full && irq_ctrl[1]) begin
        if (irq_ctrl[2]) begin
          clock_now = 1'b1;
        end else begin
          prescale -= PRESCALE_STEP;
          clock_now = (prescale <= 0);
          if (clock_now) prescale += PRESCALE_PERIOD;
        end
        if (clock_now) begin
          irq_count = irq_count + 8'd1;
          if (irq_count == 8'd0) begin
            irq_count = irq_latch;
            irq_flag = 1'b1;
          end
        end
      end
      MODE_PRG_MAP: begin
        slot = it.address[14:13];
        if (cfg_full && !slot[0] && misc_reg[1]) slot[1] = ~slot[1];
        if (slot[1]) r.bank = {4'h0, FIXED_BANK_HI, slot[0]};
        else r.bank = {4'h0, prg_bank[slot[0]]};
      end
      MODE_CHR_MAP: r.bank = chr_bank[it.address[12:10]];
    endcase
    r.mirroring = cfg_full ? mirror_reg[1:0] : {1'b0, mirror_reg[0]};
    r.irq = irq_flag;
    return r;
  endfunction

  function automatic void push_req(mode_t m, logic [15:0] a, logic [7:0] d);
    item_t it;
    it.mode = m;
    it.address = a;
    it.data = d;
    bus_requests.push_back(it);
  endfunction

  function automatic void push_random();
    item_t it;
    int    r;
    it.mode = mode_t'($urandom_range(3));
    it.address = 16'($urandom);
    it.data = 8'($urandom);
    r = $urandom_range(99);
    if (r < 30) begin
      it.mode = MODE_TICK;
    end else if (r < 45) begin
      it.mode = MODE_WRITE;
      it.address[15] = 1'b1;
    end else if (r < 55) begin
      it.mode = MODE_WRITE;
      it.address[15:12] = REGION_IRQ;
    end else if (r < 75) begin
      it.mode = MODE_PRG_MAP;
    end else if (r < 92) begin
      it.mode = MODE_CHR_MAP;
    end
    bus_requests.push_back(it);
  endfunction

  function automatic logic [15:0] irq_address(sel_t sel);
    logic [15:0] a;
    a = {REGION_IRQ, 12'($urandom)};
    a[cfg_a0] = sel[0];
    a[cfg_a1] = sel[1];
    return a;
  endfunction

  // load a near-full reload, enable the counter, run it, maybe acknowledge
  function automatic int push_irq_run();
    int ticks;
    if (cfg_a0 >= 12 || cfg_a1 >= 12 || cfg_a0 == cfg_a1) begin
      push_random();
      return 1;
    end
    ticks = $urandom_range(200, 20);
    push_req(MODE_WRITE, irq_address(SEL_RELOAD_LO), 8'($urandom));
    push_req(MODE_WRITE, irq_address(SEL_RELOAD_HI), 8'($urandom_range(15, 12)));
    push_req(MODE_WRITE, irq_address(SEL_CONTROL), 8'($urandom) | 8'h02);
    for (int i = 0; i < ticks; i++) push_req(MODE_TICK, 16'($urandom), 8'($urandom));
    if ($urandom_range(1)) begin
      push_req(MODE_WRITE, irq_address(SEL_ACK), 8'($urandom));
      return ticks + 4;
    end
    return ticks + 3;
  endfunction

  task automatic push_random_run(int count);
    int n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(99) < 4) begin
        n += push_irq_run();
      end else begin
        push_random();
        n++;
      end
    end
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_WIDTH-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_A0_LINE:      cfg_a0 = val;
      CFG_A1_LINE:      cfg_a1 = val;
      CFG_FULL_VARIANT: cfg_full = val[0];
      CFG_HONOR_REPEAT: cfg_repeat = val[0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (bus_requests.size() != 0 || s_tvalid || due_outputs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) due_outputs.push_back(mapper_step(on_bus));
      if (!s_tvalid || s_tready) begin
        if (bus_requests.size() > 0 && !hold_send && $urandom_range(99) >= send_idle) begin
          on_bus = bus_requests.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {on_bus.data, on_bus.address};
          s_tuser <= on_bus.mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall);
      if (m_tvalid && m_tready) begin
        if (due_outputs.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: %h", $time, m_tdata);
        end else begin
          want = due_outputs.pop_front();
          if (m_tdata[11:0] !== want.bank) begin
            errors++;
            $display("%0t: bank expected %h, got %h", $time, want.bank, m_tdata[11:0]);
          end
          if (m_tdata[13:12] !== want.mirroring) begin
            errors++;
            $display("%0t: mirroring expected %0d, got %0d", $time, want.mirroring,
                     m_tdata[13:12]);
          end
          if (m_tdata[14] !== want.irq) begin
            errors++;
            $display("%0t: irq expected %b, got %b", $time, want.irq, m_tdata[14]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    logic [3:0] a0_set [5];
    logic [3:0] a1_set [5];
    logic       full_set [5];
    logic       rep_set [5];
    int         send_set [5];
    int         stall_set [5];
    a0_set = '{4'd15, 4'd3, 4'd5, 4'd0, 4'd0};
    a1_set = '{4'd0, 4'd11, 4'd2, 4'd15, 4'd1};
    full_set = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    rep_set = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    send_set = '{45, 0, 27, 27, 0};
    stall_set = '{0, 45, 27, 27, 0};
    reset_mapper();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // lookups out of reset
    push_req(MODE_PRG_MAP, 16'h0000, 8'h00);
    push_req(MODE_PRG_MAP, 16'hFFFF, 8'hFF);
    push_req(MODE_CHR_MAP, 16'hFFFF, 8'h00);
    push_req(MODE_CHR_MAP, 16'h0000, 8'hFF);
    // ignored low write, program banks, fixed slot
    push_req(MODE_WRITE, 16'h7FFF, 8'hFF);
    push_req(MODE_WRITE, 16'h8000, 8'hFF);
    push_req(MODE_WRITE, 16'hA000, 8'h5A);
    push_req(MODE_PRG_MAP, 16'h4000, 8'h00);
    push_req(MODE_PRG_MAP, 16'h2000, 8'h00);
    // mirroring, ignored selects, program swap
    push_req(MODE_WRITE, 16'h9000, 8'hFF);
    push_req(MODE_WRITE, 16'h9001, 8'h00);
    push_req(MODE_WRITE, 16'h9003, 8'h00);
    push_req(MODE_WRITE, 16'h9002, 8'h02);
    push_req(MODE_PRG_MAP, 16'h0000, 8'h00);
    push_req(MODE_PRG_MAP, 16'hC000, 8'h00);
    // pattern nibbles
    push_req(MODE_WRITE, 16'hB000, 8'hFF);
    push_req(MODE_WRITE, 16'hB001, 8'hAB);
    push_req(MODE_WRITE, 16'hE003, 8'hFF);
    push_req(MODE_CHR_MAP, 16'h0000, 8'h00);
    push_req(MODE_CHR_MAP, 16'h1C00, 8'h00);
    // counter: overflow in cycle mode, acknowledge, scanline mode, disable
    push_req(MODE_WRITE, 16'hF000, 8'h0F);
    push_req(MODE_WRITE, 16'hF001, 8'h0F);
    push_req(MODE_WRITE, 16'hF002, 8'h07);
    push_req(MODE_TICK, 16'h0000, 8'h00);
    push_req(MODE_WRITE, 16'hF003, 8'h00);
    push_req(MODE_WRITE, 16'hF002, 8'h02);
    push_req(MODE_TICK, 16'hFFFF, 8'hFF);
    push_req(MODE_WRITE, 16'hF002, 8'h00);
    push_random_run(150);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_A0_LINE, a0_set[p]);
      write_reg(CFG_A1_LINE, a1_set[p]);
      write_reg(CFG_FULL_VARIANT, {3'b000, full_set[p]});
      write_reg(CFG_HONOR_REPEAT, {3'b000, rep_set[p]});
      @(negedge clk);
      send_idle = send_set[p];
      recv_stall = stall_set[p];
      push_random_run(p == 4 ? 100 : 125);
      if (p == 2) begin
        while (bus_requests.size() > 60) @(negedge clk);
        hold_send = 1'b1;
        while (s_tvalid || due_outputs.size() != 0) @(negedge clk);
        repeat (5) @(negedge clk);
        hold_send = 1'b0;
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

@@ bank_mapper_with_scanline_irq_unit.f @@
sv/bmsi_pkg.sv
sv/bmsi_core.sv
sv/bank_mapper_with_scanline_irq_unit.sv
test/testbench.sv
